@@ sv/stlb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stlb_pkg;

  // Command codes carried in the mode field of an input word.
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DEMAP  = 2'd2,
    MODE_INVAL  = 2'd3
  } stlb_mode_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_MOD   = 3'd1,
    S_READ  = 3'd2,
    S_EXEC  = 3'd3,
    S_CLEAR = 3'd4
  } stlb_state_t;

  // Update that a way cell applies to the entry it has read.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PROMOTE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DEMAP   = 3'd3,
    OP_CLEAR   = 3'd4
  } stlb_op_t;

  // Command broadcast from the sequencer to every way cell.
  typedef struct packed {
    stlb_op_t op;
    logic     rd_en;
    logic     wr_en;
  } stlb_cmd_t;

  // Status that a way cell reports for the entry it has read.
  typedef struct packed {
    logic valid;
    logic match;
    logic free_sel;
    logic vict_sel;
  } stlb_cell_st_t;

  localparam int LOG_BITS  = 5;
  localparam int FLAG_BITS = 3;
  localparam int FLAG_WR   = 0;
  localparam int FLAG_UC   = 1;
  localparam int FLAG_SYS  = 2;

endpackage

`default_nettype wire

@@ sv/stlb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per command.
interface stlb_in_if #(parameter int AW = 48);
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  logic [AW-1:0] vaddr;
  logic          touch_lru;
  logic [AW-1:0] entry_paddr;
  logic [4:0]    entry_log_bytes;
  logic          entry_writable;
  logic          entry_uncacheable;
  logic          entry_system;

  modport source (
    output valid, mode, vaddr, touch_lru, entry_paddr, entry_log_bytes,
           entry_writable, entry_uncacheable, entry_system,
    input  ready
  );
  modport sink (
    input  valid, mode, vaddr, touch_lru, entry_paddr, entry_log_bytes,
           entry_writable, entry_uncacheable, entry_system,
    output ready
  );
endinterface

// Result channel: one word per command.
interface stlb_out_if #(parameter int AW = 48);
  logic          valid;
  logic          ready;
  logic          hit;
  logic [AW-1:0] paddr;
  logic [4:0]    log_bytes;
  logic          writable;
  logic          uncacheable;
  logic          system;

  modport source (
    output valid, hit, paddr, log_bytes, writable, uncacheable, system,
    input  ready
  );
  modport sink (
    input  valid, hit, paddr, log_bytes, writable, uncacheable, system,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/stlb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One way of the buffer: holds that way's entry for every set, compares
// the read entry with the address and ripples free and victim search to
// the next way.
module stlb_cell #(
  parameter int SETS       = 4,
  parameter int WAYS       = 8,
  parameter int PAGE_SHIFT = 12,
  parameter int ADDR_BITS  = 48,
  parameter int WAY_IDX    = 0,
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int VW = ADDR_BITS - PAGE_SHIFT
) (
  input  wire logic                        clk,
  input  wire stlb_pkg::stlb_cmd_t         cmd,
  input  wire logic [SW-1:0]               rd_addr,
  input  wire logic [SW-1:0]               wr_addr,
  input  wire logic [ADDR_BITS-1:0]        cmp_addr,
  input  wire logic [VW-1:0]               new_vbase,
  input  wire logic [VW-1:0]               new_pbase,
  input  wire logic [4:0]                  new_log,
  input  wire logic [2:0]                  new_flags,
  input  wire logic                        sel,
  input  wire logic [RW:0]                 old_rank,
  input  wire logic                        free_in,
  input  wire logic                        vict_in,
  output logic                             free_out,
  output logic                             vict_out,
  output stlb_pkg::stlb_cell_st_t          st,
  output logic [RW-1:0]                    rank,
  output logic [VW-1:0]                    pbase,
  output logic [4:0]                       log_size,
  output logic [2:0]                       flags
);
  import stlb_pkg::*;

  typedef struct packed {
    logic          valid;
    logic [RW-1:0] rank;
    logic [VW-1:0] vbase;
    logic [VW-1:0] pbase;
    logic [LOG_BITS-1:0]  lg;
    logic [FLAG_BITS-1:0] flags;
  } entry_t;

  entry_t                mem_r [SETS];
  entry_t                rd_q_r;
  entry_t                wr_d;
  logic [ADDR_BITS-1:0]  vb_full;
  logic [ADDR_BITS-1:0]  low_mask;
  logic                  is_last;

  // Entry store, one word per set, registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_d;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // Page coverage test against the entry's own page size.
  assign vb_full  = {rd_q_r.vbase, {PAGE_SHIFT{1'b0}}};
  assign low_mask = (ADDR_BITS'(1) << rd_q_r.lg) - ADDR_BITS'(1);
  assign is_last  = (rd_q_r.rank == RW'(WAYS - 1));

  // Lowest free way and first least recent way ripple along the row.
  assign free_out = free_in | ~rd_q_r.valid;
  assign vict_out = vict_in | is_last;

  always_comb begin
    st.valid    = rd_q_r.valid;
    st.match    = rd_q_r.valid && (((cmp_addr ^ vb_full) & ~low_mask) == '0);
    st.free_sel = ~free_in & ~rd_q_r.valid;
    st.vict_sel = ~vict_in & is_last;
  end

  assign rank     = rd_q_r.rank;
  assign pbase    = rd_q_r.pbase;
  assign log_size = rd_q_r.lg;
  assign flags    = rd_q_r.flags;

  // Write-back word: recency shift, fill, free or clear.
  always_comb begin
    wr_d = rd_q_r;
    unique case (cmd.op)
      OP_CLEAR: begin
        wr_d.valid = 1'b0;
        wr_d.rank  = RW'(WAY_IDX);
      end
      OP_PROMOTE, OP_INSERT: begin
        if (sel) begin
          wr_d.rank = '0;
          if (cmd.op == OP_INSERT) begin
            wr_d.valid = 1'b1;
            wr_d.vbase = new_vbase;
            wr_d.pbase = new_pbase;
            wr_d.lg    = new_log;
            wr_d.flags = new_flags;
          end
        end else if (rd_q_r.valid && ({1'b0, rd_q_r.rank} < old_rank)) begin
          wr_d.rank = rd_q_r.rank + RW'(1);
        end
      end
      OP_DEMAP: begin
        if (sel) begin
          wr_d.valid = 1'b0;
        end else if (rd_q_r.valid && ({1'b0, rd_q_r.rank} > old_rank)) begin
          wr_d.rank = rd_q_r.rank - RW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/set_assoc_tlb_variable_page_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Set-associative translation buffer with per-set LRU order and page sizes
// from 4 KiB upwards. Each request word is a lookup, insert, demap or
// invalidate-all and gives exactly one result word. The ways form a row of
// cells, each holding its way's entry for every set in a small memory with a
// registered read. For a lookup, insert or demap, with SETS a power of two
// the set is read on the accepting edge, and in the next cycle all ways
// compare in parallel, the winner is chosen and the new recency order is
// written back (for a lookup only when touch_lru is set). When SETS is
// not a power of two, the set index is first reduced eight page-number bits
// a cycle through two small constant tables and the set is read after that.
// Invalidate-all sweeps the sets one per cycle. After reset the same clearing
// sweep runs, and no request is accepted until it has ended.
module set_assoc_tlb_variable_page_core #(
  parameter int SETS       = 4,
  parameter int WAYS       = 8,
  parameter int PAGE_SHIFT = 12,
  parameter int ADDR_BITS  = 48
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  stlb_in_if.sink     in_ch,
  stlb_out_if.source  out_ch
);
  import stlb_pkg::*;

  localparam int  AW     = ADDR_BITS;
  localparam int  SW     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  RW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  VW     = AW - PAGE_SHIFT;
  localparam int  NCH    = (VW + 7) / 8;
  localparam int  CW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int  AT     = 1 << SW;
  localparam bit  ISPOW2 = ((SETS & (SETS - 1)) == 0);

  stlb_state_t   state_r, state_nxt;
  logic [SW-1:0] cnt_r;
  logic          clr_out_r;
  logic [CW-1:0] dig_cnt_r;
  logic [SW-1:0] set_r;
  stlb_mode_t    mode_r;
  logic [AW-1:0] va_r;
  logic [AW-1:0] pa_r;
  logic          touch_r;
  logic [4:0]    lg_r;
  logic [2:0]    flags_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [AW-1:0] out_pa_r;
  logic [4:0]    out_lg_r;
  logic [2:0]    out_fl_r;

  logic          in_ready;
  logic          in_acc;
  logic [4:0]    in_lg;
  logic [AW-1:0] in_low;
  logic [AW-1:0] key_in;
  logic [SW-1:0] set_in;
  logic [NCH*8-1:0] pn_ext;
  logic [7:0]    digit;
  logic [SW-1:0] shf_tab [AT];
  logic [SW-1:0] dig_tab [256];
  logic [SW:0]   rem_tmp;
  logic [SW-1:0] rem_nxt;

  stlb_cmd_t     cmd;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] wr_addr;
  logic          out_load;

  stlb_cell_st_t st      [WAYS];
  logic [RW-1:0] rank    [WAYS];
  logic [VW-1:0] pbase   [WAYS];
  logic [4:0]    lsize   [WAYS];
  logic [2:0]    eflags  [WAYS];
  logic [WAYS:0] free_ch;
  logic [WAYS:0] vict_ch;
  logic [WAYS-1:0] win;
  logic [WAYS-1:0] ins_sel;
  logic [WAYS-1:0] sel;
  logic          hit_any;
  logic [RW-1:0] win_rank;
  logic [RW-1:0] ins_rank;
  logic [VW-1:0] win_pb;
  logic [4:0]    win_lg;
  logic [2:0]    win_fl;
  logic [RW:0]   old_rank;
  logic          res_hit;
  logic [AW-1:0] res_pa;
  logic [4:0]    res_lg;
  logic [2:0]    res_fl;

  // Input side: page-size floor, alignment of an insert, set of a power-of-two
  // set count.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc   = in_ch.valid && in_ready;
  assign in_lg    = (in_ch.entry_log_bytes < 5'(PAGE_SHIFT)) ? 5'(PAGE_SHIFT)
                                                             : in_ch.entry_log_bytes;
  assign in_low   = (AW'(1) << in_lg) - AW'(1);
  assign key_in   = (stlb_mode_t'(in_ch.mode) == MODE_INSERT) ? (in_ch.vaddr & ~in_low)
                                                              : in_ch.vaddr;
  generate
    if (SETS > 1 && ISPOW2) begin : g_set_pow2
      assign set_in = key_in[PAGE_SHIFT +: SW];
    end else begin : g_set_none
      assign set_in = '0;
    end
  endgenerate

  // Residue tables: a partial set index shifted up by one byte, and a byte,
  // each reduced modulo SETS.
  generate
    for (genvar i = 0; i < AT; i++) begin : g_shf_tab
      assign shf_tab[i] = SW'((i * 256) % SETS);
    end
    for (genvar i = 0; i < 256; i++) begin : g_dig_tab
      assign dig_tab[i] = SW'(i % SETS);
    end
  endgenerate

  // Set index modulo SETS, one page-number byte a cycle from the top.
  assign pn_ext = (NCH*8)'(va_r[AW-1:PAGE_SHIFT]);
  assign digit  = pn_ext[int'(dig_cnt_r)*8 +: 8];

  always_comb begin
    rem_tmp = {1'b0, shf_tab[set_r]} + {1'b0, dig_tab[digit]};
    if (rem_tmp >= (SW+1)'(SETS)) begin
      rem_tmp = rem_tmp - (SW+1)'(SETS);
    end
    rem_nxt = rem_tmp[SW-1:0];
  end

  // Row of way cells.
  assign free_ch[0] = 1'b0;
  assign vict_ch[0] = 1'b0;
  generate
    for (genvar w = 0; w < WAYS; w++) begin : g_way
      stlb_cell #(
        .SETS(SETS), .WAYS(WAYS), .PAGE_SHIFT(PAGE_SHIFT),
        .ADDR_BITS(ADDR_BITS), .WAY_IDX(w)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .cmp_addr (va_r),
        .new_vbase(va_r[AW-1:PAGE_SHIFT]),
        .new_pbase(pa_r[AW-1:PAGE_SHIFT]),
        .new_log  (lg_r),
        .new_flags(flags_r),
        .sel      (sel[w]),
        .old_rank (old_rank),
        .free_in  (free_ch[w]),
        .vict_in  (vict_ch[w]),
        .free_out (free_ch[w+1]),
        .vict_out (vict_ch[w+1]),
        .st       (st[w]),
        .rank     (rank[w]),
        .pbase    (pbase[w]),
        .log_size (lsize[w]),
        .flags    (eflags[w])
      );
    end
  endgenerate

  // Most recent covering way: no other match holds a lower rank.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      win[i] = st[i].match;
      for (int j = 0; j < WAYS; j++) begin
        if (j != i && st[j].match && (rank[j] < rank[i])) begin
          win[i] = 1'b0;
        end
      end
    end
  end

  // Insert target: lowest free way, else least recent, else way zero.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (free_ch[WAYS]) begin
        ins_sel[i] = st[i].free_sel;
      end else if (vict_ch[WAYS]) begin
        ins_sel[i] = st[i].vict_sel;
      end else begin
        ins_sel[i] = (i == 0);
      end
    end
  end

  // Fields of the chosen ways, gathered by OR.
  always_comb begin
    hit_any  = 1'b0;
    win_rank = '0;
    ins_rank = '0;
    win_pb   = '0;
    win_lg   = '0;
    win_fl   = '0;
    for (int i = 0; i < WAYS; i++) begin
      hit_any  = hit_any | st[i].match;
      win_rank = win_rank | (rank[i] & {RW{win[i]}});
      ins_rank = ins_rank | (rank[i] & {RW{ins_sel[i]}});
      win_pb   = win_pb | (pbase[i] & {VW{win[i]}});
      win_lg   = win_lg | (lsize[i] & {5{win[i]}});
      win_fl   = win_fl | (eflags[i] & {3{win[i]}});
    end
  end

  assign sel = (mode_r == MODE_INSERT) ? ins_sel : win;

  always_comb begin
    if (mode_r == MODE_INSERT) begin
      old_rank = free_ch[WAYS] ? (RW+1)'(WAYS) : {1'b0, ins_rank};
    end else begin
      old_rank = {1'b0, win_rank};
    end
  end

  // Result word of the current command.
  always_comb begin
    res_hit = 1'b0;
    res_pa  = '0;
    res_lg  = '0;
    res_fl  = '0;
    if (state_r == S_EXEC && hit_any) begin
      if (mode_r == MODE_LOOKUP) begin
        res_hit = 1'b1;
        res_pa  = {win_pb, {PAGE_SHIFT{1'b0}}} | (va_r & ((AW'(1) << win_lg) - AW'(1)));
        res_lg  = win_lg;
        res_fl  = win_fl;
      end else if (mode_r == MODE_DEMAP) begin
        res_hit = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (stlb_mode_t'(in_ch.mode) == MODE_INVAL) begin
            state_nxt = S_CLEAR;
          end else if (ISPOW2) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (dig_cnt_r == '0) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      S_CLEAR: begin
        if (cnt_r == SW'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the cells and output load.
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.rd_en = 1'b0;
    cmd.wr_en = 1'b0;
    rd_addr   = set_r;
    wr_addr   = set_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr   = set_in;
        cmd.rd_en = in_acc && ISPOW2 && (stlb_mode_t'(in_ch.mode) != MODE_INVAL);
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_EXEC: begin
        out_load = 1'b1;
        unique case (mode_r)
          MODE_INSERT: begin
            cmd.op    = OP_INSERT;
            cmd.wr_en = 1'b1;
          end
          MODE_LOOKUP: begin
            cmd.op    = OP_PROMOTE;
            cmd.wr_en = hit_any && touch_r;
          end
          MODE_DEMAP: begin
            cmd.op    = OP_DEMAP;
            cmd.wr_en = hit_any;
          end
          default: begin
          end
        endcase
      end
      S_CLEAR: begin
        cmd.op    = OP_CLEAR;
        cmd.wr_en = 1'b1;
        wr_addr   = cnt_r;
        out_load  = clr_out_r && (cnt_r == SW'(SETS - 1));
      end
      default: begin
      end
    endcase
  end

  // Sequencer and request registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      clr_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        if (cnt_r == SW'(SETS - 1)) begin
          cnt_r     <= '0;
          clr_out_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + SW'(1);
        end
      end else if (in_acc && stlb_mode_t'(in_ch.mode) == MODE_INVAL) begin
        clr_out_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= stlb_mode_t'(in_ch.mode);
      va_r      <= key_in;
      pa_r      <= in_ch.entry_paddr & ~in_low;
      touch_r   <= in_ch.touch_lru;
      lg_r      <= in_lg;
      flags_r   <= {in_ch.entry_system, in_ch.entry_uncacheable, in_ch.entry_writable};
      set_r     <= set_in;
      dig_cnt_r <= CW'(NCH - 1);
    end else if (state_r == S_MOD) begin
      set_r     <= rem_nxt;
      dig_cnt_r <= dig_cnt_r - CW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r <= res_hit;
      out_pa_r  <= res_pa;
      out_lg_r  <= res_lg;
      out_fl_r  <= res_fl;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.paddr       = out_pa_r;
  assign out_ch.log_bytes   = out_lg_r;
  assign out_ch.writable    = out_fl_r[FLAG_WR];
  assign out_ch.uncacheable = out_fl_r[FLAG_UC];
  assign out_ch.system      = out_fl_r[FLAG_SYS];

  // Checks on the selection, the output register and the clearing sweep.
  a_win_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(win))
    else $error("more than one way won a lookup");

  a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && mode_r == MODE_INSERT) |-> $onehot(ins_sel))
    else $error("insert selected no way or several ways");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten before it was taken");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request accepted during clearing sweep");

endmodule

`default_nettype wire

@@ tb/set_assoc_tlb_variable_page_core_tb.sv @@
`timescale 1ns / 1ps

module set_assoc_tlb_variable_page_core_tb;
  import stlb_pkg::*;

  localparam int SETS = 4;
  localparam int WAYS = 8;
  localparam int PSH = 12;
  localparam int AW = 48;
  localparam int NENT = SETS * WAYS;
  localparam int WDOG_LIMIT = 20000;
  localparam int MAXW = 1024;

  typedef struct packed {
    stlb_mode_t  mode;
    logic [47:0] vaddr;
    logic        touch;
    logic [47:0] paddr;
    logic [4:0]  lg;
    logic        wr;
    logic        uc;
    logic        sys;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] paddr;
    logic [4:0]  lg;
    logic        wr;
    logic        uc;
    logic        sys;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stlb_in_if #(.AW(AW)) in_ch ();
  stlb_out_if #(.AW(AW)) out_ch ();

  set_assoc_tlb_variable_page_core #(
    .SETS(SETS), .WAYS(WAYS), .PAGE_SHIFT(PSH), .ADDR_BITS(AW)
  ) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow copy of the translation entries.
  logic        tv_valid [NENT];
  logic [35:0] tv_vbase [NENT];
  logic [35:0] tv_pbase [NENT];
  logic [4:0]  tv_lg    [NENT];
  logic [2:0]  tv_flags [NENT];
  int          tv_rank  [NENT];

  // Pending request words and expected result words, each an array with
  // separate write and read counts.
  req_t  pend_q [MAXW];
  int    pend_wr = 0;
  int    pend_rd = 0;
  resp_t exp_q [MAXW];
  int    exp_wr = 0;
  int    exp_rd = 0;
  int    mismatches = 0;
  bit    stim_done = 0;
  bit    calm = 0;
  int    hold_off = 0;
  int    idle_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_word(req_t r);
    pend_q[pend_wr] = r;
    pend_wr++;
  endfunction

  function automatic void shadow_clear();
    for (int e = 0; e < NENT; e++) begin
      tv_valid[e] = 1'b0;
      tv_vbase[e] = '0;
      tv_pbase[e] = '0;
      tv_lg[e] = '0;
      tv_flags[e] = '0;
      tv_rank[e] = e % WAYS;
    end
  endfunction

  // Moves way w of set s to the front; younger valid ways age by one.
  function automatic void move_to_front(int s, int w, int old_rank);
    for (int k = 0; k < WAYS; k++)
      if (k != w && tv_valid[s*WAYS+k] && tv_rank[s*WAYS+k] < old_rank)
        tv_rank[s*WAYS+k]++;
    tv_rank[s*WAYS+w] = 0;
  endfunction

  // Works out the result word of one request and updates the shadow state.
  function automatic resp_t translate(req_t r);
    resp_t o;
    int s, w, e, best_rank, lg, rk;
    logic [47:0] vb, lowm, rv, rp;
    o = '0;
    if (r.mode == MODE_LOOKUP || r.mode == MODE_DEMAP) begin
      s = int'((r.vaddr >> PSH) % SETS);
      w = -1;
      best_rank = 0;
      for (int k = 0; k < WAYS; k++) begin
        e = s*WAYS + k;
        if (tv_valid[e]) begin
          vb = {tv_vbase[e], 12'h000};
          if ((r.vaddr >> tv_lg[e]) == (vb >> tv_lg[e]) &&
              (w < 0 || tv_rank[e] < best_rank)) begin
            w = k;
            best_rank = tv_rank[e];
          end
        end
      end
      if (w < 0) return o;
      e = s*WAYS + w;
      rk = tv_rank[e];
      o.hit = 1'b1;
      if (r.mode == MODE_LOOKUP) begin
        lowm = (48'd1 << tv_lg[e]) - 48'd1;
        o.paddr = {tv_pbase[e], 12'h000} | (r.vaddr & lowm);
        o.lg = tv_lg[e];
        o.wr = tv_flags[e][FLAG_WR];
        o.uc = tv_flags[e][FLAG_UC];
        o.sys = tv_flags[e][FLAG_SYS];
        if (r.touch) move_to_front(s, w, rk);
      end else begin
        tv_valid[e] = 1'b0;
        for (int k = 0; k < WAYS; k++)
          if (tv_valid[s*WAYS+k] && tv_rank[s*WAYS+k] > rk) tv_rank[s*WAYS+k]--;
      end
    end else if (r.mode == MODE_INSERT) begin
      lg = (r.lg < PSH) ? PSH : r.lg;
      lowm = (48'd1 << lg) - 48'd1;
      rv = r.vaddr & ~lowm;
      rp = r.paddr & ~lowm;
      s = int'((rv >> PSH) % SETS);
      w = -1;
      rk = WAYS;
      for (int k = 0; k < WAYS; k++)
        if (w < 0 && !tv_valid[s*WAYS+k]) w = k;
      if (w < 0) begin
        for (int k = 0; k < WAYS; k++)
          if (w < 0 && tv_rank[s*WAYS+k] == WAYS-1) w = k;
        if (w < 0) w = 0;
        rk = tv_rank[s*WAYS+w];
      end
      e = s*WAYS + w;
      tv_valid[e] = 1'b1;
      tv_vbase[e] = rv[47:12];
      tv_pbase[e] = rp[47:12];
      tv_lg[e] = lg[4:0];
      tv_flags[e] = {r.sys, r.uc, r.wr};
      move_to_front(s, w, rk);
    end else begin
      for (int e2 = 0; e2 < NENT; e2++) begin
        tv_valid[e2] = 1'b0;
        tv_rank[e2] = e2 % WAYS;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Random address from a small pool of pages so that hits are common.
  function automatic logic [47:0] pick_addr();
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    if ($urandom_range(0, 9) < 8)
      a = {24'h0, 4'h0, $urandom_range(0, 15) > 12 ? 8'hff : 8'h00,
           12'h000} | (a & 48'h0000_0003_ffff);
    return a;
  endfunction

  function automatic req_t rand_req(stlb_mode_t m);
    req_t r;
    int big;
    r.mode = m;
    r.vaddr = pick_addr();
    r.touch = 1'($urandom_range(0, 1));
    r.paddr = 48'({$urandom, $urandom});
    big = int'($urandom_range(0, 9));
    r.lg = big == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(12, 16));
    r.wr = 1'($urandom_range(0, 1));
    r.uc = 1'($urandom_range(0, 1));
    r.sys = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t mk(stlb_mode_t m, logic [47:0] va, logic [47:0] pa,
                              logic [4:0] lg, logic [2:0] fl, logic t);
    req_t r;
    r.mode = m; r.vaddr = va; r.paddr = pa; r.lg = lg; r.touch = t;
    r.wr = fl[0]; r.uc = fl[1]; r.sys = fl[2];
    return r;
  endfunction

  // Stimulus: directed words, then random traffic.
  initial begin
    int n, pick;
    shadow_clear();
    queue_word(mk(MODE_LOOKUP, 48'h0, 48'h0, 5'd0, 3'b000, 1'b0));
    queue_word(mk(MODE_INSERT, 48'h0, 48'hffff_ffff_ffff, 5'd0, 3'b111, 1'b0));
    queue_word(mk(MODE_LOOKUP, 48'h0000_0000_0fff, 48'h0, 5'd0, 3'b0, 1'b1));
    queue_word(mk(MODE_INSERT, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
                  5'd31, 3'b101, 1'b0));
    queue_word(mk(MODE_LOOKUP, 48'hffff_ffff_ffff, 48'h0, 5'd0, 3'b0, 1'b0));
    queue_word(mk(MODE_INSERT, 48'h0000_4000_1234, 48'h1234_5678_9abc,
                  5'd30, 3'b010, 1'b0));
    queue_word(mk(MODE_LOOKUP, 48'h0000_4000_1234, 48'h0, 5'd0, 3'b0, 1'b1));
    queue_word(mk(MODE_LOOKUP, 48'h0000_4000_3234, 48'h0, 5'd0, 3'b0, 1'b0));
    queue_word(mk(MODE_INSERT, 48'h0000_0000_5000, 48'h0abc_0000_0000,
                  5'd12, 3'b001, 1'b0));
    // Overfill set 1 to force replacement of the oldest way.
    for (int k = 0; k < 10; k++)
      queue_word(mk(MODE_INSERT, 48'h1000 + 48'(k) * 48'h4000,
                    48'(k) << 20, 5'd12, 3'(k), 1'b0));
    queue_word(mk(MODE_LOOKUP, 48'h9000, 48'h0, 5'd0, 3'b0, 1'b1));
    queue_word(mk(MODE_DEMAP, 48'h9000, 48'h0, 5'd0, 3'b0, 1'b0));
    queue_word(mk(MODE_DEMAP, 48'h9000, 48'h0, 5'd0, 3'b0, 1'b0));
    queue_word(mk(MODE_INVAL, 48'h0, 48'h0, 5'd0, 3'b0, 1'b0));
    queue_word(mk(MODE_LOOKUP, 48'h1000, 48'h0, 5'd0, 3'b0, 1'b0));
    for (n = 0; n < 400; n++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 40) queue_word(rand_req(MODE_LOOKUP));
      else if (pick < 80) queue_word(rand_req(MODE_INSERT));
      else if (pick < 97) queue_word(rand_req(MODE_DEMAP));
      else queue_word(rand_req(MODE_INVAL));
    end
    stim_done = 1;
  end

  // Reset sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: offers the next word, with random gaps.
  int gap_left = 0;
  int sent = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.vaddr = '0;
    in_ch.touch_lru = 1'b0;
    in_ch.entry_paddr = '0;
    in_ch.entry_log_bytes = '0;
    in_ch.entry_writable = 1'b0;
    in_ch.entry_uncacheable = 1'b0;
    in_ch.entry_system = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    req_t r;
    bit busy;
    busy = in_ch.valid && !in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      r = pend_q[pend_rd];
      pend_rd++;
      exp_q[exp_wr] = translate(r);
      exp_wr++;
      sent++;
      calm <= (sent > 360);
    end
    if (!rst_n || busy) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap_left <= int'($urandom_range(0, 9));
      in_ch.valid <= 1'b0;
    end else if (pend_wr > pend_rd && stim_done) begin
      r = pend_q[pend_rd];
      in_ch.valid <= 1'b1;
      in_ch.mode <= r.mode;
      in_ch.vaddr <= r.vaddr;
      in_ch.touch_lru <= r.touch;
      in_ch.entry_paddr <= r.paddr;
      in_ch.entry_log_bytes <= r.lg;
      in_ch.entry_writable <= r.wr;
      in_ch.entry_uncacheable <= r.uc;
      in_ch.entry_system <= r.sys;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Monitor: checks each result word against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    resp_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (exp_rd == exp_wr) begin
        report_mismatch("unexpected result word", 48'(out_ch.hit), 48'd0);
      end else begin
        w = exp_q[exp_rd];
        exp_rd++;
        if (out_ch.hit !== w.hit) report_mismatch("hit", 48'(out_ch.hit), 48'(w.hit));
        if (out_ch.paddr !== w.paddr) report_mismatch("paddr", out_ch.paddr, w.paddr);
        if (out_ch.log_bytes !== w.lg)
          report_mismatch("log_bytes", 48'(out_ch.log_bytes), 48'(w.lg));
        if (out_ch.writable !== w.wr)
          report_mismatch("writable", 48'(out_ch.writable), 48'(w.wr));
        if (out_ch.uncacheable !== w.uc)
          report_mismatch("uncacheable", 48'(out_ch.uncacheable), 48'(w.uc));
        if (out_ch.system !== w.sys)
          report_mismatch("system", 48'(out_ch.system), 48'(w.sys));
      end
    end
    // Receiver stalls: one long hold-off early on, then random bursts.
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off == 0 && sent >= 30) begin
      hold_off <= 1;
      stall_left <= 200;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= int'($urandom_range(0, 9));
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (pend_rd == pend_wr && exp_rd == exp_wr);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
